// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

    localparam int WordWidth = 32;
    localparam int FracWidth = 5;
    localparam int FuncWidth = 4;
    localparam int WideWidth = 2 * WordWidth;
    localparam int DivCells  = WideWidth;

    typedef enum logic [FuncWidth-1:0] {
        FUNC_ADD  = 4'd0,
        FUNC_SUB  = 4'd1,
        FUNC_MUL  = 4'd2,
        FUNC_DIV  = 4'd3,
        FUNC_CMP  = 4'd4,
        FUNC_MAX  = 4'd5,
        FUNC_MIN  = 4'd6,
        FUNC_INC  = 4'd7,
        FUNC_DEC  = 4'd8,
        FUNC_REQ  = 4'd9,
        FUNC_INT  = 4'd10
    } t_func;

    typedef struct packed {
        logic [FuncWidth-1:0] func;
        logic [WordWidth-1:0] value;
        logic [FracWidth-1:0] frac;
        logic                 lt;
        logic                 eq;
        logic                 gt;
        logic                 dz;
        logic [WideWidth-1:0] prod;
        logic                 q_neg;
    } t_item;

    typedef struct packed {
        logic [WordWidth-1:0] rem;
        logic [WideWidth-1:0] num;
        logic [WordWidth-1:0] den;
        logic [WordWidth-1:0] quo;
    } t_div;

endpackage

// ===== rtl/fixed_point_alu.sv =====
// channel  | handshake          | payload
// request  | i_valid / o_stall  | i_func i_a_value i_a_frac i_b_value i_b_frac
// result   | o_valid / i_stall  | o_result_value o_result_frac o_less o_equal
//          |                    | o_greater o_div_by_zero
//
// One request per cycle while o_stall is low; each result passes through
// two front stages (align, compare, multiply), 64 divider cells of one
// quotient bit each, and the output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled result is held in the output register and the next one in a
// skid register; the chain freezes only while the skid register is full.
module fixed_point_alu (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [fpa_pkg::FuncWidth-1:0]        i_func,
    input  logic signed [fpa_pkg::WordWidth-1:0] i_a_value,
    input  logic [fpa_pkg::FracWidth-1:0]        i_a_frac,
    input  logic signed [fpa_pkg::WordWidth-1:0] i_b_value,
    input  logic [fpa_pkg::FracWidth-1:0]        i_b_frac,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [fpa_pkg::WordWidth-1:0] o_result_value,
    output logic [fpa_pkg::FracWidth-1:0]        o_result_frac,
    output logic                                 o_less,
    output logic                                 o_equal,
    output logic                                 o_greater,
    output logic                                 o_div_by_zero
);

    logic           en;
    logic           v    [fpa_pkg::DivCells+1];
    fpa_pkg::t_item item [fpa_pkg::DivCells+1];
    fpa_pkg::t_div  dv   [fpa_pkg::DivCells+1];

    fpa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_func    (i_func),
        .i_a_value (i_a_value),
        .i_a_frac  (i_a_frac),
        .i_b_value (i_b_value),
        .i_b_frac  (i_b_frac),
        .o_valid   (v[0]),
        .o_item    (item[0]),
        .o_div     (dv[0])
    );

    for (genvar k = 0; k < fpa_pkg::DivCells; k++) begin : g_cell
        fpa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[k]),
            .i_item  (item[k]),
            .i_div   (dv[k]),
            .o_valid (v[k+1]),
            .o_item  (item[k+1]),
            .o_div   (dv[k+1])
        );
    end

    fpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[fpa_pkg::DivCells]),
        .i_item  (item[fpa_pkg::DivCells]),
        .i_div   (dv[fpa_pkg::DivCells]),
        .i_stall (i_stall),
        .o_en    (en),
        .o_valid (o_valid),
        .o_value (o_result_value),
        .o_frac  (o_result_frac),
        .o_lt    (o_less),
        .o_eq    (o_equal),
        .o_gt    (o_greater),
        .o_dz    (o_div_by_zero)
    );

    assign o_stall = !en;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid register full while output register empty");

    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_less, o_equal, o_greater, o_div_by_zero}))
        else $error("more than one result flag set");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_by_zero) |-> (o_result_value == '0))
        else $error("divide by zero with nonzero result");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_less || o_equal || o_greater))
            |-> (o_result_value == '0 && o_result_frac == '0))
        else $error("compare result carries a value");

endmodule

// ===== rtl/fpa_front.sv =====
module fpa_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [fpa_pkg::FuncWidth-1:0]  i_func,
    input  logic signed [fpa_pkg::WordWidth-1:0] i_a_value,
    input  logic [fpa_pkg::FracWidth-1:0]  i_a_frac,
    input  logic signed [fpa_pkg::WordWidth-1:0] i_b_value,
    input  logic [fpa_pkg::FracWidth-1:0]  i_b_frac,
    output logic                           o_valid,
    output fpa_pkg::t_item                 o_item,
    output fpa_pkg::t_div                  o_div
);

    logic [fpa_pkg::FracWidth-1:0]        f;
    logic signed [fpa_pkg::WordWidth-1:0] aa;
    logic signed [fpa_pkg::WordWidth-1:0] ba;
    logic signed [fpa_pkg::WideWidth-1:0] ca;
    logic signed [fpa_pkg::WideWidth-1:0] cb;
    logic                                 c_lt;
    logic                                 c_eq;
    fpa_pkg::t_item                       n_a;

    logic                                 r_va;
    fpa_pkg::t_item                       r_a;
    logic signed [fpa_pkg::WordWidth-1:0] r_aa;
    logic signed [fpa_pkg::WordWidth-1:0] r_ba;
    logic [fpa_pkg::FracWidth-1:0]        r_f;

    logic signed [fpa_pkg::WideWidth-1:0] num_s;
    logic                                 num_neg;
    logic                                 den_neg;
    fpa_pkg::t_item                       n_b;
    fpa_pkg::t_div                        n_d;

    logic                                 r_vb;
    fpa_pkg::t_item                       r_b;
    fpa_pkg::t_div                        r_d;

    always_comb begin
        f  = (i_a_frac < i_b_frac) ? i_a_frac : i_b_frac;
        aa = i_a_value >>> (i_a_frac - f);
        ba = i_b_value >>> (i_b_frac - f);
        ca = fpa_pkg::WideWidth'(i_a_value);
        cb = fpa_pkg::WideWidth'(i_b_value);
        if (i_a_frac < i_b_frac) begin
            ca = ca <<< (i_b_frac - i_a_frac);
        end else begin
            cb = cb <<< (i_a_frac - i_b_frac);
        end
        c_lt = ca < cb;
        c_eq = ca == cb;

        n_a       = '0;
        n_a.func  = i_func;
        case (i_func)
            fpa_pkg::FUNC_ADD: begin
                n_a.value = aa + ba;
                n_a.frac  = f;
            end
            fpa_pkg::FUNC_SUB: begin
                n_a.value = aa - ba;
                n_a.frac  = f;
            end
            fpa_pkg::FUNC_MUL: begin
                n_a.frac  = f;
            end
            fpa_pkg::FUNC_DIV: begin
                n_a.frac  = f;
                n_a.dz    = ba == '0;
            end
            fpa_pkg::FUNC_CMP: begin
                n_a.lt = c_lt;
                n_a.eq = c_eq;
                n_a.gt = !c_lt && !c_eq;
            end
            fpa_pkg::FUNC_MAX: begin
                n_a.value = c_lt ? i_b_value : i_a_value;
                n_a.frac  = c_lt ? i_b_frac : i_a_frac;
            end
            fpa_pkg::FUNC_MIN: begin
                n_a.value = (c_lt || c_eq) ? i_a_value : i_b_value;
                n_a.frac  = (c_lt || c_eq) ? i_a_frac : i_b_frac;
            end
            fpa_pkg::FUNC_INC: begin
                n_a.value = i_a_value + fpa_pkg::WordWidth'(1);
                n_a.frac  = i_a_frac;
            end
            fpa_pkg::FUNC_DEC: begin
                n_a.value = i_a_value - fpa_pkg::WordWidth'(1);
                n_a.frac  = i_a_frac;
            end
            fpa_pkg::FUNC_REQ: begin
                if (i_a_frac < i_b_frac) begin
                    n_a.value = i_a_value << (i_b_frac - i_a_frac);
                end else begin
                    n_a.value = i_a_value >>> (i_a_frac - i_b_frac);
                end
                n_a.frac = i_b_frac;
            end
            fpa_pkg::FUNC_INT: begin
                n_a.value = i_a_value >>> i_a_frac;
            end
            default: begin
                n_a.func = i_func;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
        if (i_en) begin
            r_a  <= n_a;
            r_aa <= aa;
            r_ba <= ba;
            r_f  <= f;
        end
    end

    always_comb begin
        num_s   = fpa_pkg::WideWidth'(r_aa) <<< r_f;
        num_neg = num_s[fpa_pkg::WideWidth-1];
        den_neg = r_ba[fpa_pkg::WordWidth-1];
        n_b       = r_a;
        n_b.prod  = fpa_pkg::WideWidth'(r_aa) * fpa_pkg::WideWidth'(r_ba);
        n_b.q_neg = num_neg ^ den_neg;
        n_d.rem   = '0;
        n_d.num   = num_neg ? -num_s : num_s;
        n_d.den   = den_neg ? -r_ba : r_ba;
        n_d.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_vb <= r_va;
        end
        if (i_en) begin
            r_b <= n_b;
            r_d <= n_d;
        end
    end

    assign o_valid = r_vb;
    assign o_item  = r_b;
    assign o_div   = r_d;

endmodule

// ===== rtl/fpa_div_cell.sv =====
module fpa_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  fpa_pkg::t_item i_item,
    input  fpa_pkg::t_div  i_div,
    output logic           o_valid,
    output fpa_pkg::t_item o_item,
    output fpa_pkg::t_div  o_div
);

    logic [fpa_pkg::WordWidth:0] trial;
    logic                        fit;
    fpa_pkg::t_div               n_div;
    logic                        r_valid;
    fpa_pkg::t_item              r_item;
    fpa_pkg::t_div               r_div;

    always_comb begin
        trial     = {i_div.rem, i_div.num[fpa_pkg::WideWidth-1]};
        fit       = trial >= {1'b0, i_div.den};
        n_div     = i_div;
        n_div.num = {i_div.num[fpa_pkg::WideWidth-2:0], 1'b0};
        n_div.quo = {i_div.quo[fpa_pkg::WordWidth-2:0], fit};
        n_div.rem = fit ? fpa_pkg::WordWidth'(trial - {1'b0, i_div.den})
                        : fpa_pkg::WordWidth'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_item <= i_item;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_div   = r_div;

endmodule

// ===== rtl/fpa_back.sv =====
module fpa_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  fpa_pkg::t_item                i_item,
    input  fpa_pkg::t_div                 i_div,
    input  logic                          i_stall,
    output logic                          o_en,
    output logic                          o_valid,
    output logic [fpa_pkg::WordWidth-1:0] o_value,
    output logic [fpa_pkg::FracWidth-1:0] o_frac,
    output logic                          o_lt,
    output logic                          o_eq,
    output logic                          o_gt,
    output logic                          o_dz
);

    logic signed [fpa_pkg::WideWidth-1:0] prod_s;
    fpa_pkg::t_item                       n_fin;
    logic                                 r_skid_v;
    fpa_pkg::t_item                       r_skid;
    logic                                 r_out_v;
    fpa_pkg::t_item                       r_out;
    logic                                 out_free;

    always_comb begin
        prod_s = i_item.prod;
        n_fin  = i_item;
        case (i_item.func)
            fpa_pkg::FUNC_MUL: begin
                n_fin.value = fpa_pkg::WordWidth'(prod_s >>> i_item.frac);
            end
            fpa_pkg::FUNC_DIV: begin
                if (i_item.dz) begin
                    n_fin.value = '0;
                end else begin
                    n_fin.value = i_item.q_neg ? -i_div.quo : i_div.quo;
                end
            end
            default: begin
                n_fin.value = i_item.value;
            end
        endcase
    end

    assign o_en     = !r_skid_v;
    assign out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_free) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (out_free) begin
            r_out_v <= i_valid;
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
        if (r_skid_v) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (out_free) begin
            r_out <= n_fin;
        end else begin
            r_skid <= n_fin;
        end
    end

    assign o_valid = r_out_v;
    assign o_value = r_out.value;
    assign o_frac  = r_out.frac;
    assign o_lt    = r_out.lt;
    assign o_eq    = r_out.eq;
    assign o_gt    = r_out.gt;
    assign o_dz    = r_out.dz;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam logic [fpa_pkg::FuncWidth-1:0] FUNC_SPARE_LO = 4'd11;
    localparam logic [fpa_pkg::FuncWidth-1:0] FUNC_SPARE_HI = 4'd15;
    localparam int RandomCount = 1050;
    localparam int HoldAt      = 200;
    localparam int HoldCycles  = 500;
    localparam int PauseAt     = 500;
    localparam int CalmLo      = 700;
    localparam int CalmHi      = 860;
    localparam int IdlePct     = 11;
    localparam int WatchLimit  = 4000;

    typedef struct {
        logic [fpa_pkg::FuncWidth-1:0]        func;
        logic signed [fpa_pkg::WordWidth-1:0] a_value;
        logic [fpa_pkg::FracWidth-1:0]        a_frac;
        logic signed [fpa_pkg::WordWidth-1:0] b_value;
        logic [fpa_pkg::FracWidth-1:0]        b_frac;
        bit                                   pause;
    } t_alu_req;

    typedef struct {
        logic signed [fpa_pkg::WordWidth-1:0] value;
        logic [fpa_pkg::FracWidth-1:0]        frac;
        logic                                 less;
        logic                                 equal;
        logic                                 greater;
        logic                                 div_by_zero;
    } t_alu_res;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic [fpa_pkg::FuncWidth-1:0]        i_func;
    logic signed [fpa_pkg::WordWidth-1:0] i_a_value;
    logic [fpa_pkg::FracWidth-1:0]        i_a_frac;
    logic signed [fpa_pkg::WordWidth-1:0] i_b_value;
    logic [fpa_pkg::FracWidth-1:0]        i_b_frac;
    logic                                 o_valid;
    logic                                 i_stall;
    logic signed [fpa_pkg::WordWidth-1:0] o_result_value;
    logic [fpa_pkg::FracWidth-1:0]        o_result_frac;
    logic                                 o_less;
    logic                                 o_equal;
    logic                                 o_greater;
    logic                                 o_div_by_zero;

    t_alu_req pending_reqs[$];
    t_alu_res expected_results[$];
    int       errors = 0;
    int       reqs_sent = 0;
    int       watch_count = 0;
    int       hold_count = 0;
    bit       hold_done = 0;
    bit       req_taken = 0;
    bit       pausing = 0;

    fixed_point_alu dut (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int cmp_aligned(logic signed [63:0] a, int af,
                                       logic signed [63:0] b, int bf);
        if (af < bf) a = a <<< (bf - af);
        else b = b <<< (af - bf);
        return (a < b) ? -1 : ((a == b) ? 0 : 1);
    endfunction

    function automatic t_alu_res alu_predict(t_alu_req r);
        t_alu_res           res;
        logic signed [63:0] a, b, aa, ba, w;
        int                 af, bf, f, c;
        res = '{default: 0};
        a = r.a_value;
        b = r.b_value;
        af = r.a_frac;
        bf = r.b_frac;
        f = (af < bf) ? af : bf;
        aa = a >>> (af - f);
        ba = b >>> (bf - f);
        case (r.func)
            fpa_pkg::FUNC_ADD: begin
                w = aa + ba;
                res.value = w[31:0];
                res.frac = fpa_pkg::FracWidth'(f);
            end
            fpa_pkg::FUNC_SUB: begin
                w = aa - ba;
                res.value = w[31:0];
                res.frac = fpa_pkg::FracWidth'(f);
            end
            fpa_pkg::FUNC_MUL: begin
                w = (aa * ba) >>> f;
                res.value = w[31:0];
                res.frac = fpa_pkg::FracWidth'(f);
            end
            fpa_pkg::FUNC_DIV: begin
                res.frac = fpa_pkg::FracWidth'(f);
                if (ba == 0) begin
                    res.div_by_zero = 1'b1;
                end else begin
                    w = (aa <<< f) / ba;
                    res.value = w[31:0];
                end
            end
            fpa_pkg::FUNC_CMP: begin
                c = cmp_aligned(a, af, b, bf);
                res.less = c < 0;
                res.equal = c == 0;
                res.greater = c > 0;
            end
            fpa_pkg::FUNC_MAX, fpa_pkg::FUNC_MIN: begin
                c = cmp_aligned(a, af, b, bf);
                if ((r.func == fpa_pkg::FUNC_MAX) ? (c >= 0) : (c <= 0)) begin
                    res.value = r.a_value;
                    res.frac = r.a_frac;
                end else begin
                    res.value = r.b_value;
                    res.frac = r.b_frac;
                end
            end
            fpa_pkg::FUNC_INC: begin
                res.value = r.a_value + 32'sd1;
                res.frac = r.a_frac;
            end
            fpa_pkg::FUNC_DEC: begin
                res.value = r.a_value - 32'sd1;
                res.frac = r.a_frac;
            end
            fpa_pkg::FUNC_REQ: begin
                if (af < bf) w = a <<< (bf - af);
                else w = a >>> (af - bf);
                res.value = w[31:0];
                res.frac = r.b_frac;
            end
            fpa_pkg::FUNC_INT: begin
                w = a >>> af;
                res.value = w[31:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return $signed($urandom_range(0, 64)) - 32;
            2: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
            3: return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_alu_req mk_req(int fn, logic [31:0] av, int af,
                                        logic [31:0] bv, int bf);
        t_alu_req r;
        r.func = fpa_pkg::FuncWidth'(fn);
        r.a_value = av;
        r.a_frac = fpa_pkg::FracWidth'(af);
        r.b_value = bv;
        r.b_frac = fpa_pkg::FracWidth'(bf);
        r.pause = 0;
        return r;
    endfunction

    function automatic bit idle_roll();
        if (reqs_sent >= CalmLo && reqs_sent < CalmHi) return 0;
        return $urandom_range(0, 99) < IdlePct;
    endfunction

    initial begin
        t_alu_req r;
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_func = fpa_pkg::FUNC_ADD;
        i_a_value = 0;
        i_a_frac = 0;
        i_b_value = 0;
        i_b_frac = 0;

        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_ADD, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_SUB, 32'h8000_0000, 31, 1, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_MUL, 32'h8000_0000, 0, 32'h8000_0000, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_MUL, 32'h8000_0000, 31, 32'h7FFF_FFFF, 31));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_DIV, 32'h1234, 4, 0, 4));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_DIV, 5, 0, 32'h8, 4));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_DIV, 32'h8000_0000, 31, 32'hFFFF_FFFF, 31));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_DIV, -7, 0, 2, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_CMP, 1, 0, 2, 1));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_CMP, 32'h8000_0000, 0, 32'h7FFF_FFFF, 31));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_CMP, 3, 1, 1, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_MAX, 4, 2, 1, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_MIN, 4, 2, 1, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_MAX, -5, 3, 9, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_MIN, -5, 3, 9, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_INC, 32'h7FFF_FFFF, 31, 0, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_DEC, 32'h8000_0000, 0, 0, 31));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_REQ, 32'h4000_0001, 0, 0, 31));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_REQ, -3, 31, 0, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_INT, -1, 31, 0, 0));
        pending_reqs.push_back(mk_req(fpa_pkg::FUNC_INT, 32'h7FFF_FFFF, 0, 0, 0));
        pending_reqs.push_back(mk_req(FUNC_SPARE_LO, -1, 31, -1, 31));
        pending_reqs.push_back(mk_req(FUNC_SPARE_HI, -1, 31, -1, 31));
        for (int i = 0; i < RandomCount; i++) begin
            if (i == PauseAt) begin
                r = mk_req(fpa_pkg::FUNC_ADD, 0, 0, 0, 0);
                r.pause = 1;
                pending_reqs.push_back(r);
            end
            r = mk_req($urandom_range(0, 19) == 0 ? $urandom_range(FUNC_SPARE_LO,
                        FUNC_SPARE_HI) : $urandom_range(fpa_pkg::FUNC_ADD,
                        fpa_pkg::FUNC_INT),
                       rand_value(), $urandom_range(0, 31), rand_value(),
                       $urandom_range(0, 31));
            pending_reqs.push_back(r);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        while (pending_reqs.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_results.push_back(alu_predict(mk_req(i_func, i_a_value, i_a_frac,
                                                          i_b_value, i_b_frac)));
            reqs_sent <= reqs_sent + 1;
        end
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall)))
            watch_count <= 0;
        else if (i_rst_n)
            watch_count <= watch_count + 1;
        if (watch_count >= WatchLimit) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (pending_reqs.size() > 0 && pending_reqs[0].pause) begin
                i_valid <= 0;
                if (expected_results.size() == 0 && pausing)
                    void'(pending_reqs.pop_front());
                pausing <= 1;
            end else if (pending_reqs.size() == 0 || idle_roll()) begin
                i_valid <= 0;
            end else begin
                i_valid <= 1;
                i_func <= pending_reqs[0].func;
                i_a_value <= pending_reqs[0].a_value;
                i_a_frac <= pending_reqs[0].a_frac;
                i_b_value <= pending_reqs[0].b_value;
                i_b_frac <= pending_reqs[0].b_frac;
                void'(pending_reqs.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        if (!hold_done && reqs_sent >= HoldAt) begin
            i_stall <= 1;
            hold_count <= hold_count + 1;
            if (hold_count >= HoldCycles) hold_done <= 1;
        end else begin
            i_stall <= idle_roll();
        end
    end

    always @(posedge i_clk) begin
        t_alu_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result value=%0d", o_result_value);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_result_value !== e.value) begin
                    $error("result_value exp %0d got %0d", e.value, o_result_value);
                    errors++;
                end
                if (o_result_frac !== e.frac) begin
                    $error("result_frac exp %0d got %0d", e.frac, o_result_frac);
                    errors++;
                end
                if (o_less !== e.less) begin
                    $error("less exp %0b got %0b", e.less, o_less);
                    errors++;
                end
                if (o_equal !== e.equal) begin
                    $error("equal exp %0b got %0b", e.equal, o_equal);
                    errors++;
                end
                if (o_greater !== e.greater) begin
                    $error("greater exp %0b got %0b", e.greater, o_greater);
                    errors++;
                end
                if (o_div_by_zero !== e.div_by_zero) begin
                    $error("div_by_zero exp %0b got %0b", e.div_by_zero, o_div_by_zero);
                    errors++;
                end
            end
        end
    end

endmodule
